FILE: design/brp_pkg.sv
// ----------------------------------------------------------------------------
// Balanced range partitioner package
// Shared widths, the job word passed from front to back, and front states.
// ----------------------------------------------------------------------------
package brp_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned PartsW     = 6;
  localparam int unsigned IndexW     = 5;
  localparam int unsigned ResultCap  = 32;
  localparam int unsigned QueueDepth = 2;

  typedef logic [DataW-1:0]  data_t;
  typedef logic [PartsW-1:0] parts_t;

  typedef struct packed {
    data_t  lo;
    data_t  stop;
    data_t  per;
    parts_t rem;
    parts_t parts;
  } job_t;

  typedef enum logic [2:0] {
    FrIdle,
    FrDiv1,
    FrDiv2,
    FrDiv3,
    FrPush
  } front_state_e;

endpackage

FILE: design/brp_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brp_divider
  import brp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  data_t dividend_i,
  input  data_t divisor_i,
  output logic  done_o,
  output data_t quotient_o,
  output data_t remainder_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  data_t           rem_q;
  data_t           quo_q;
  data_t           div_q;
  logic [DataW:0]  shifted;
  logic [DataW:0]  diff;
  logic            last_step;

  assign shifted   = {rem_q, quo_q[DataW-1]};
  assign diff      = shifted - {1'b0, div_q};
  assign last_step = (cnt_q == CntW'(DataW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= diff[DataW] ? shifted[DataW-1:0] : diff[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], ~diff[DataW]};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: design/brp_front.sv
// ----------------------------------------------------------------------------
// Partitioner front end
// Accepts a range, settles part count, base size and remainder with the
// serial divider, and hands the finished job to the queue.
// ----------------------------------------------------------------------------
module brp_front
  import brp_pkg::*;
#(
  parameter int unsigned CAP_PARTS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  data_t        range_begin_i,
  input  data_t        range_end_i,
  input  parts_t       target_parts_i,
  input  data_t        min_size_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output job_t         push_job_o
);

  localparam parts_t CapP = PartsW'(CAP_PARTS);

  front_state_e state_q, state_d;
  data_t        first_q, stop_q, count_q, minsz_q, per_q;
  parts_t       parts_q, rem_q;

  data_t  in_count;
  parts_t in_parts;
  parts_t quo_parts;
  logic   div_start, div_done;
  data_t  div_dividend, div_divisor, div_quo, div_rem;
  logic   load_in, load_parts, load_result;

  assign in_count = (range_end_i > range_begin_i) ? (range_end_i - range_begin_i) : '0;

  always_comb begin
    in_parts = (target_parts_i == '0) ? parts_t'(1) : target_parts_i;
    if (in_parts > CapP) begin
      in_parts = CapP;
    end
    if (div_quo == '0) begin
      quo_parts = parts_t'(1);
    end else if (div_quo > DataW'(CAP_PARTS)) begin
      quo_parts = CapP;
    end else begin
      quo_parts = div_quo[PartsW-1:0];
    end
  end

  brp_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    div_start    = 1'b0;
    div_dividend = count_q;
    div_divisor  = minsz_q;
    load_in      = 1'b0;
    load_parts   = 1'b0;
    load_result  = 1'b0;
    unique case (state_q)
      FrIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load_in      = 1'b1;
          div_start    = 1'b1;
          div_dividend = in_count;
          div_divisor  = DataW'(in_parts);
          state_d      = FrDiv1;
        end
      end
      FrDiv1: begin
        if (div_done) begin
          if (div_quo < minsz_q) begin
            div_start = 1'b1;
            state_d   = FrDiv2;
          end else begin
            load_result = 1'b1;
            state_d     = FrPush;
          end
        end
      end
      FrDiv2: begin
        if (div_done) begin
          load_parts  = 1'b1;
          div_start   = 1'b1;
          div_divisor = DataW'(quo_parts);
          state_d     = FrDiv3;
        end
      end
      FrDiv3: begin
        if (div_done) begin
          load_result = 1'b1;
          state_d     = FrPush;
        end
      end
      FrPush: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = FrIdle;
        end
      end
      default: begin
        state_d = FrIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      first_q <= range_begin_i;
      stop_q  <= range_begin_i + in_count;
      count_q <= in_count;
      minsz_q <= min_size_i;
      parts_q <= in_parts;
    end else if (load_parts) begin
      parts_q <= quo_parts;
    end
    if (load_result) begin
      per_q <= div_quo;
      rem_q <= div_rem[PartsW-1:0];
    end
  end

  assign push_job_o = '{lo: first_q, stop: stop_q, per: per_q, rem: rem_q, parts: parts_q};

endmodule

FILE: design/brp_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out buffer of jobs between front end and back end.
// ----------------------------------------------------------------------------
module brp_queue
  import brp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  localparam int unsigned PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  job_t             entry_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign push_ready_o = (fill_q != FillW'(QueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: design/brp_back.sv
// ----------------------------------------------------------------------------
// Partitioner back end
// Walks one job and emits its sub-ranges, one word per cycle while the output
// is not stalled, through an output register.
// ----------------------------------------------------------------------------
module brp_back
  import brp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  job_t              pop_job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output data_t             part_begin_o,
  output data_t             part_end_o,
  output logic [IndexW-1:0] part_index_o,
  output logic              last_part_o
);

  logic              active_q;
  logic              out_valid_q;
  logic [IndexW-1:0] idx_q;
  data_t             lo_q, stop_q, per_q;
  parts_t            rem_q, parts_q;
  data_t             part_begin_q, part_end_q;
  logic [IndexW-1:0] part_index_q;
  logic              last_part_q;

  logic   do_pop, emit, done;
  parts_t idx_ext;
  data_t  size, room, hi;

  assign pop_ready_o = !active_q;
  assign do_pop      = pop_valid_i && !active_q;
  assign emit        = active_q && (!out_valid_q || out_ready_i);

  always_comb begin
    idx_ext = PartsW'(idx_q);
    size    = per_q + DataW'(idx_ext < rem_q);
    room    = stop_q - lo_q;
    hi      = (size > room) ? stop_q : (lo_q + size);
    done    = (hi == stop_q) || ((idx_ext + 1'b1) == parts_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (do_pop) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 1'b1;
        if (done) begin
          active_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      lo_q    <= pop_job_i.lo;
      stop_q  <= pop_job_i.stop;
      per_q   <= pop_job_i.per;
      rem_q   <= pop_job_i.rem;
      parts_q <= pop_job_i.parts;
    end else if (emit) begin
      lo_q <= hi;
    end
    if (emit) begin
      part_begin_q <= lo_q;
      part_end_q   <= hi;
      part_index_q <= idx_q;
      last_part_q  <= done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign part_begin_o = part_begin_q;
  assign part_end_o   = part_end_q;
  assign part_index_o = part_index_q;
  assign last_part_o  = last_part_q;

endmodule

FILE: design/balanced_range_partitioner.sv
// ----------------------------------------------------------------------------
// Balanced range partitioner: front end runs one or three serial 32-bit
// divisions per range in the divider. Queued jobs pass to the back end,
// which emits one word a cycle through its output register unless stalled.
// Reset is asynchronous and active low; it empties the queue and all valids.
// ----------------------------------------------------------------------------
module balanced_range_partitioner
  import brp_pkg::*;
#(
  parameter int unsigned MAX_PARTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       range_begin_i,
  input  logic [31:0]       range_end_i,
  input  logic [5:0]        target_parts_i,
  input  logic [31:0]       min_size_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       part_begin_o,
  output logic [31:0]       part_end_o,
  output logic [IndexW-1:0] part_index_o,
  output logic              last_part_o
);

  localparam int unsigned CapParts = (MAX_PARTS > ResultCap) ? ResultCap :
                                     ((MAX_PARTS < 1) ? 1 : MAX_PARTS);

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  brp_front #(
    .CAP_PARTS (CapParts)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .range_begin_i  (range_begin_i),
    .range_end_i    (range_end_i),
    .target_parts_i (target_parts_i),
    .min_size_i     (min_size_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_job_o     (push_job)
  );

  brp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  brp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_job_i    (pop_job),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .part_begin_o (part_begin_o),
    .part_end_o   (part_end_o),
    .part_index_o (part_index_o),
    .last_part_o  (last_part_o)
  );

`ifndef SYNTHESIS
  a_part_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (part_end_o >= part_begin_o))
    else $error("Emitted sub-range ends before it begins.");

  a_rem_below_parts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> (push_job.rem < push_job.parts))
    else $error("Job remainder is not below its part count.");

  a_parts_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> ((push_job.parts != '0) && (push_job.parts <= PartsW'(CapParts))))
    else $error("Job part count is outside its allowed range.");

  a_stop_after_lo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> (push_job.stop >= push_job.lo))
    else $error("Job stop index lies below its first index.");
`endif

endmodule
